[design/two_way_lru_write_back_cache_macros.svh]
// Assertion macros for the two-way LRU write-back cache.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef TWO_WAY_LRU_WRITE_BACK_CACHE_MACROS_SVH
`define TWO_WAY_LRU_WRITE_BACK_CACHE_MACROS_SVH

// Check a property on a given clock, disabled while the active-low reset is asserted.
`define TLWBC_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on the block clock and reset (clk_i, rst_ni).
`define TLWBC_ASSERT(lbl, prop, msg) \
  `TLWBC_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[design/tlwbc_pkg.sv]
// Package for the two-way LRU write-back cache: widths, defaults, FSM codes
// and the controller/datapath command and status structs. No dependencies.
package tlwbc_pkg;

  // Fixed field widths
  localparam int unsigned AddrW = 32;
  localparam int unsigned CntW  = 32;

  // Parameter defaults (SETS must be a power of two)
  localparam int unsigned DefSets           = 512;
  localparam int unsigned DefLineOffsetBits = 6;

  // Per-set state row: LRU bit plus valid and dirty bits of both ways
  typedef struct packed {
    logic       lru;
    logic [1:0] valid;
    logic [1:0] dirty;
  } set_state_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_LOOKUP = 3'b100
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;   // write one zero state row and advance the sweep
    logic accept;  // capture the transaction and read the set
    logic lookup;  // compare, update the set and present the result
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_done;  // the sweep is writing its last row
    logic result;      // a result is on the outputs this cycle
  } stat_t;

endpackage

[design/tlwbc_ctrl.sv]
// Controller of the two-way LRU write-back cache: reset sweep, idle, lookup.
// Depends on tlwbc_pkg and the assertion macro header.
`include "two_way_lru_write_back_cache_macros.svh"

module tlwbc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  tlwbc_pkg::stat_t stat_i,
  output tlwbc_pkg::cmd_t  cmd_o,
  output logic           busy_o
);

  tlwbc_pkg::state_e state_q, state_d;

  // Sequence the sweep and each transaction
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      tlwbc_pkg::ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clear_done) state_d = tlwbc_pkg::ST_IDLE;
      end
      tlwbc_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          state_d      = tlwbc_pkg::ST_LOOKUP;
        end
      end
      tlwbc_pkg::ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = tlwbc_pkg::ST_IDLE;
      end
      default: state_d = tlwbc_pkg::ST_CLEAR;
    endcase
  end

  assign busy_o = (state_q != tlwbc_pkg::ST_IDLE);

  // Hold the state; restart the sweep on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tlwbc_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  `TLWBC_ASSERT(a_accept_then_lookup, cmd_o.accept |=> (state_q == tlwbc_pkg::ST_LOOKUP), "accepted transaction did not enter lookup")
  `TLWBC_ASSERT(a_result_after_lookup, cmd_o.lookup |=> (stat_i.result && !busy_o), "lookup not followed by a result in idle")

endmodule

[design/tlwbc_dpath.sv]
// Datapath of the two-way LRU write-back cache: tag and set-state memories,
// tag compare, LRU/dirty update, saturating totals and result registers.
// Depends on tlwbc_pkg and the assertion macro header.
`include "two_way_lru_write_back_cache_macros.svh"

module tlwbc_dpath #(
  parameter int unsigned SETS             = tlwbc_pkg::DefSets,
  parameter int unsigned LINE_OFFSET_BITS = tlwbc_pkg::DefLineOffsetBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tlwbc_pkg::cmd_t              cmd_i,
  output tlwbc_pkg::stat_t             stat_o,
  input  logic                         action_i,
  input  logic [tlwbc_pkg::AddrW-1:0]  address_i,
  output logic                         done_o,
  output logic                         hit_o,
  output logic                         writeback_o,
  output logic [tlwbc_pkg::CntW-1:0]   misses_so_far_o,
  output logic [tlwbc_pkg::CntW-1:0]   writebacks_so_far_o
);

  localparam int unsigned SetW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned TagW = tlwbc_pkg::AddrW - LINE_OFFSET_BITS - SetW;
  localparam int unsigned CntW = tlwbc_pkg::CntW;

  // Memories: one row per set
  logic [1:0][TagW-1:0]   tag_mem_q [SETS];
  tlwbc_pkg::set_state_t  st_mem_q  [SETS];

  logic [SetW-1:0]        set_in;
  logic [SetW-1:0]        clr_idx_q;
  logic [SetW-1:0]        set_q;
  logic [TagW-1:0]        tag_q;
  logic                   act_q;
  logic [1:0][TagW-1:0]   tag_rd_q;
  tlwbc_pkg::set_state_t  st_rd_q;

  logic                   hit0, hit1, hit_d, wb_d, victim;
  tlwbc_pkg::set_state_t  st_d;
  logic [1:0][TagW-1:0]   tag_row_d;
  logic [CntW-1:0]        miss_total_q, miss_total_d;
  logic [CntW-1:0]        wb_total_q, wb_total_d;
  logic                   done_q, hit_q, wb_q;

  assign set_in = address_i[LINE_OFFSET_BITS +: SetW];

  // Advance the reset sweep over the state memory
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q <= '0;
    end else if (cmd_i.clear) begin
      clr_idx_q <= clr_idx_q + SetW'(1);
    end
  end

  assign stat_o.clear_done = (clr_idx_q == SetW'(SETS - 1));
  assign stat_o.result     = done_q;

  // Capture the transaction and read its set
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      act_q    <= action_i;
      set_q    <= set_in;
      tag_q    <= address_i[tlwbc_pkg::AddrW-1 -: TagW];
      tag_rd_q <= tag_mem_q[set_in];
      st_rd_q  <= st_mem_q[set_in];
    end
  end

  // Compare both ways and work out the new set row
  always_comb begin
    hit0      = st_rd_q.valid[0] && (tag_rd_q[0] == tag_q);
    hit1      = st_rd_q.valid[1] && (tag_rd_q[1] == tag_q) && !hit0;
    hit_d     = hit0 || hit1;
    victim    = st_rd_q.lru;
    st_d      = st_rd_q;
    tag_row_d = tag_rd_q;
    wb_d      = 1'b0;
    if (hit_d) begin
      st_d.lru = hit0;
      if (act_q) st_d.dirty[hit1] = 1'b1;
    end else begin
      wb_d                 = st_rd_q.valid[victim] && st_rd_q.dirty[victim];
      st_d.valid[victim]   = 1'b1;
      st_d.dirty[victim]   = act_q;
      st_d.lru             = !victim;
      tag_row_d[victim]    = tag_q;
    end
  end

  // Write the state memory: zero rows during the sweep, updated rows on lookup
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      st_mem_q[clr_idx_q] <= '0;
    end else if (cmd_i.lookup) begin
      st_mem_q[set_q] <= st_d;
    end
  end

  // Refill the tag row on a miss
  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup && !hit_d) begin
      tag_mem_q[set_q] <= tag_row_d;
    end
  end

  // Saturating totals
  always_comb begin
    miss_total_d = miss_total_q;
    wb_total_d   = wb_total_q;
    if (!hit_d && (miss_total_q != '1)) miss_total_d = miss_total_q + CntW'(1);
    if (wb_d && (wb_total_q != '1))     wb_total_d   = wb_total_q + CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      miss_total_q <= '0;
      wb_total_q   <= '0;
      done_q       <= 1'b0;
    end else begin
      done_q <= cmd_i.lookup;
      if (cmd_i.lookup) begin
        miss_total_q <= miss_total_d;
        wb_total_q   <= wb_total_d;
      end
    end
  end

  // Hold the result flags for the strobe cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      hit_q <= hit_d;
      wb_q  <= wb_d;
    end
  end

  assign done_o              = done_q;
  assign hit_o               = hit_q;
  assign writeback_o         = wb_q;
  assign misses_so_far_o     = miss_total_q;
  assign writebacks_so_far_o = wb_total_q;

  `TLWBC_ASSERT(a_hit_no_writeback, done_q |-> !(hit_q && wb_q), "write-back reported on a hit")
  `TLWBC_ASSERT(a_hit_totals_hold, (done_q && hit_q) |-> ($stable(miss_total_q) && $stable(wb_total_q)), "totals moved on a hit")
  `TLWBC_ASSERT(a_miss_counts, (done_q && !hit_q && ($past(miss_total_q) != '1)) |-> (miss_total_q == CntW'($past(miss_total_q) + CntW'(1))), "miss total did not advance by one")

endmodule

[design/two_way_lru_write_back_cache.sv]
// Top level of the two-way set-associative LRU write-back cache tag controller.
// Depends on tlwbc_pkg, tlwbc_ctrl and tlwbc_dpath.
//
// Usage:
//   Command channel: drive action_i (0 load, 1 store) and address_i with
//   start_i high; the access is taken at the rising edge where busy_o is low.
//   Result channel: done_o is high for exactly one cycle with hit_o,
//   writeback_o, misses_so_far_o and writebacks_so_far_o valid; the receiver
//   must take it in that cycle, there is no back-pressure.
// Sequence: the access is captured at the accepting edge, compared in lookup
//   and its result registered; no access is taken during lookup. The set's
//   tag and state rows are read from registered-output memories at the accept
//   edge and written back at the following edge; busy_o is low again while
//   the result is shown, so the next access can be taken in the strobe cycle.
// Reset: rst_ni is asynchronous, active low. Afterwards a clearing pass
//   writes the state memory (valid, dirty, LRU) one set per cycle, with
//   busy_o high; totals start at zero. Tags need no clear.
// SETS must be a power of two; the set is the line number modulo SETS and
//   the tag the remaining upper address bits.
module two_way_lru_write_back_cache #(
  parameter int unsigned SETS             = tlwbc_pkg::DefSets,
  parameter int unsigned LINE_OFFSET_BITS = tlwbc_pkg::DefLineOffsetBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        action_i,
  input  logic [tlwbc_pkg::AddrW-1:0] address_i,
  output logic                        done_o,
  output logic                        hit_o,
  output logic                        writeback_o,
  output logic [tlwbc_pkg::CntW-1:0]  misses_so_far_o,
  output logic [tlwbc_pkg::CntW-1:0]  writebacks_so_far_o
);

  tlwbc_pkg::cmd_t  cmd;
  tlwbc_pkg::stat_t stat;

  // Controller
  tlwbc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // Datapath
  tlwbc_dpath #(
    .SETS             (SETS),
    .LINE_OFFSET_BITS (LINE_OFFSET_BITS)
  ) u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .action_i            (action_i),
    .address_i           (address_i),
    .done_o              (done_o),
    .hit_o               (hit_o),
    .writeback_o         (writeback_o),
    .misses_so_far_o     (misses_so_far_o),
    .writebacks_so_far_o (writebacks_so_far_o)
  );

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// Testbench for two_way_lru_write_back_cache: directed and random loads and stores with a
// predictor of tags, valid/dirty/LRU state and running totals. Depends on tlwbc_pkg and the RTL.
module tb;

  localparam int unsigned AddrW   = tlwbc_pkg::AddrW;
  localparam int unsigned CntW    = tlwbc_pkg::CntW;
  localparam int unsigned NumSets = tlwbc_pkg::DefSets;
  localparam int unsigned OffBits = tlwbc_pkg::DefLineOffsetBits;
  localparam int unsigned SetBits = $clog2(NumSets);
  localparam int unsigned TagBits = AddrW - SetBits - OffBits;

  typedef enum logic {
    ACC_LOAD  = 1'b0,
    ACC_STORE = 1'b1
  } access_e;

  typedef struct packed {
    logic            hit;
    logic            writeback;
    logic [CntW-1:0] misses;
    logic [CntW-1:0] writebacks;
  } access_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start_i = 1'b0;
  logic             action_i = 1'b0;
  logic [AddrW-1:0] address_i = '0;
  logic             busy_o;
  logic             done_o;
  logic             hit_o;
  logic             writeback_o;
  logic [CntW-1:0]  misses_so_far_o;
  logic [CntW-1:0]  writebacks_so_far_o;

  two_way_lru_write_back_cache dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .action_i           (action_i),
    .address_i          (address_i),
    .done_o             (done_o),
    .hit_o              (hit_o),
    .writeback_o        (writeback_o),
    .misses_so_far_o    (misses_so_far_o),
    .writebacks_so_far_o(writebacks_so_far_o)
  );

  // Shadow cache state
  logic [TagBits-1:0] shadow_tag   [NumSets][2];
  logic               shadow_valid [NumSets][2];
  logic               shadow_dirty [NumSets][2];
  logic               shadow_lru   [NumSets];
  logic [CntW-1:0]    shadow_misses;
  logic [CntW-1:0]    shadow_wbs;

  access_result_t expected_results[$];

  int unsigned errors;
  int unsigned n_accepted;
  int unsigned n_hits;
  int unsigned n_wbs;
  bit          idle_on = 1'b1;

  // Pools that keep random traffic on a few sets so lines get reused and evicted
  logic [SetBits-1:0] set_pool[4];
  logic [TagBits-1:0] tag_pool[3];

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #400us;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic [AddrW-1:0] mk_addr(input logic [TagBits-1:0] tag,
                                               input logic [SetBits-1:0] set_idx,
                                               input logic [OffBits-1:0] off);
    return {tag, set_idx, off};
  endfunction

  function automatic logic [CntW-1:0] sat_incr(input logic [CntW-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Look up one access in the shadow cache, update it and return the expected result
  function automatic access_result_t cache_access(input access_e acc,
                                                  input logic [AddrW-1:0] addr);
    logic [SetBits-1:0] s;
    logic [TagBits-1:0] tag;
    access_result_t     r;
    int                 w;
    logic               v;
    s   = addr[OffBits +: SetBits];
    tag = addr[AddrW-1 -: TagBits];
    r   = '0;
    for (w = 0; w < 2; w++) begin
      if (!r.hit && shadow_valid[s][w] && shadow_tag[s][w] == tag) begin
        r.hit = 1'b1;
        if (acc == ACC_STORE) shadow_dirty[s][w] = 1'b1;
        shadow_lru[s] = (w == 0);
      end
    end
    if (!r.hit) begin
      v = shadow_lru[s];
      shadow_misses = sat_incr(shadow_misses);
      if (shadow_valid[s][v] && shadow_dirty[s][v]) begin
        r.writeback = 1'b1;
        shadow_wbs  = sat_incr(shadow_wbs);
      end
      shadow_tag[s][v]   = tag;
      shadow_valid[s][v] = 1'b1;
      shadow_dirty[s][v] = (acc == ACC_STORE);
      shadow_lru[s]      = ~v;
    end
    r.misses     = shadow_misses;
    r.writebacks = shadow_wbs;
    return r;
  endfunction

  task automatic check_field(input string fld, input logic [CntW-1:0] exp_v,
                             input logic [CntW-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, fld, exp_v, act_v);
      errors++;
    end
  endtask

  // Check each result against the oldest expectation, then predict any transaction taken now
  always @(posedge clk_i) begin
    access_result_t exp_r;
    if (rst_ni && done_o) begin
      if (hit_o) n_hits++;
      if (writeback_o) n_wbs++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: hit %0b writeback %0b misses %0h writebacks %0h",
                 $time, hit_o, writeback_o, misses_so_far_o, writebacks_so_far_o);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        check_field("hit", CntW'(exp_r.hit), CntW'(hit_o));
        check_field("writeback", CntW'(exp_r.writeback), CntW'(writeback_o));
        check_field("misses_so_far", exp_r.misses, misses_so_far_o);
        check_field("writebacks_so_far", exp_r.writebacks, writebacks_so_far_o);
      end
    end
    if (rst_ni && start_i && !busy_o) begin
      n_accepted++;
      expected_results.push_back(cache_access(access_e'(action_i), address_i));
    end
  end

  // Offer one access and hold it until taken; then maybe drop start for a short burst
  task automatic send_access(input access_e acc, input logic [AddrW-1:0] addr);
    int unsigned gap;
    start_i   <= 1'b1;
    action_i  <= acc;
    address_i <= addr;
    do @(posedge clk_i); while (busy_o);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      start_i   <= 1'b0;
      action_i  <= 1'($urandom_range(0, 1));
      address_i <= $urandom;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain;
    start_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic pick_pools;
    foreach (set_pool[i]) set_pool[i] = SetBits'($urandom_range(0, NumSets - 1));
    foreach (tag_pool[i]) tag_pool[i] = TagBits'($urandom);
    // keep the edge sets and tags in play now and then
    if ($urandom_range(0, 1)) set_pool[0] = '1;
    if ($urandom_range(0, 1)) tag_pool[0] = '0;
  endtask

  task automatic send_pool_access;
    if ($urandom_range(0, 99) < 85)
      send_access(access_e'($urandom_range(0, 1)),
                  mk_addr(tag_pool[$urandom_range(0, 2)], set_pool[$urandom_range(0, 3)],
                          OffBits'($urandom)));
    else
      send_access(access_e'($urandom_range(0, 1)), $urandom);
  endtask

  // Fills, hits, dirty evictions, clean evictions and address extremes
  task automatic test_directed;
    send_access(ACC_LOAD,  32'h0000_0000);
    send_access(ACC_STORE, 32'h0000_003F);
    send_access(ACC_LOAD,  mk_addr(17'd1, 9'd0, 6'd0));
    send_access(ACC_LOAD,  mk_addr(17'd2, 9'd0, 6'd0));
    send_access(ACC_STORE, 32'hFFFF_FFFF);
    send_access(ACC_LOAD,  32'hFFFF_FFC0);
    send_access(ACC_STORE, mk_addr(17'd0, '1, 6'd0));
    send_access(ACC_LOAD,  mk_addr(17'h10000, '1, 6'd0));
    send_access(ACC_LOAD,  mk_addr(17'd0, '1, 6'h3F));
    send_access(ACC_STORE, mk_addr(17'h15555, 9'h155, 6'h2A));
    send_access(ACC_LOAD,  mk_addr(17'h0AAAA, 9'h0AA, 6'h15));
    send_access(ACC_LOAD,  32'h8000_0000);
    send_access(ACC_STORE, mk_addr(17'd2, 9'd0, 6'd5));
    send_access(ACC_LOAD,  mk_addr(17'd3, 9'd0, 6'd0));
    send_access(ACC_LOAD,  mk_addr(17'd4, 9'd0, 6'd0));
    send_access(ACC_STORE, mk_addr(17'd4, 9'd0, 6'd0));
    send_access(ACC_STORE, mk_addr(17'd5, 9'd0, 6'd0));
    send_access(ACC_LOAD,  mk_addr(17'd5, 9'd0, 6'h3F));
    send_access(ACC_STORE, 32'h7FFF_FFFF);
    send_access(ACC_LOAD,  mk_addr(17'h1FFFF, 9'h100, 6'd0));
    drain();
  endtask

  // Reuse-heavy traffic on a few sets, re-picked now and then, with some stray addresses
  task automatic test_set_thrash;
    for (int i = 0; i < 250; i++) begin
      if (i % 60 == 0) pick_pools();
      send_pool_access();
    end
    drain();
  endtask

  // Fully random addresses and actions
  task automatic test_random_spread;
    for (int i = 0; i < 150; i++)
      send_access(access_e'($urandom_range(0, 1)), $urandom);
    drain();
  endtask

  task automatic send_access_nogap;
    send_pool_access();
  endtask

  // Back-to-back transactions with no idling
  task automatic test_back_to_back;
    idle_on = 1'b0;
    pick_pools();
    for (int i = 0; i < 130; i++) send_access_nogap();
    drain();
  endtask

  initial begin
    errors        = 0;
    n_accepted    = 0;
    n_hits        = 0;
    n_wbs         = 0;
    shadow_misses = '0;
    shadow_wbs    = '0;
    foreach (shadow_lru[s]) begin
      shadow_lru[s] = 1'b0;
      for (int w = 0; w < 2; w++) begin
        shadow_tag[s][w]   = '0;
        shadow_valid[s][w] = 1'b0;
        shadow_dirty[s][w] = 1'b0;
      end
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_set_thrash();
    test_random_spread();
    test_back_to_back();

    $display("Covered %0d accesses: %0d hits, %0d misses, %0d dirty evictions.",
             n_accepted, n_hits, shadow_misses, n_wbs);
    $display("Traffic: directed fills/evictions, set thrashing, random spread, back-to-back.");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
